// File: rtl/lkvc_pkg.sv
// Shared types and constants for the LRU key/value cache.
// Used by the cell, the top level and the port checker; no dependencies.
package lkvc_pkg;

	localparam int KEY_W       = 32;
	localparam int DATA_W      = 32;
	localparam int CAP_W       = 4;
	localparam int ENTRIES_DEF = 8;
	localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] data;
	} entry_t;

	typedef enum logic {
		ST_IDLE,
		ST_UPDATE
	} state_t;

endpackage

// File: rtl/lkvc_cell.sv
// One slot of the recency-ordered chain: holds an entry, compares its key
// and loads from its upstream neighbor when told to. Depends on lkvc_pkg.
module lkvc_cell import lkvc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmp_en,
	input  logic [KEY_W-1:0] cmp_key,
	input  logic             take,
	input  entry_t           prev,
	input  logic             next_valid,
	output entry_t           ent,
	output logic             match,
	output logic             tail
);

	logic              valid_q;
	logic              match_q;
	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (cmp_en) begin
				match_q <= valid_q && (key_q == cmp_key);
			end
			if (take) begin
				valid_q <= prev.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			key_q  <= prev.key;
			data_q <= prev.data;
		end
	end

	assign ent   = '{valid: valid_q, key: key_q, data: data_q};
	assign match = match_q;
	// Valid entries stay packed at the head, so the last valid cell is the oldest.
	assign tail  = valid_q & ~next_valid;

endmodule

// File: rtl/lru_key_value_cache.sv
// LRU key/value cache that handles one item at a time. In the cycle an item is
// accepted every cell compares its key against the request; then, in the update
// state, the chain of cells is reordered (most recent at the head) and the result
// is written to the output register, which holds it until taken. If the previous
// result is still waiting, the update state waits with it. Depends on lkvc_pkg
// and lkvc_cell.
module lru_key_value_cache import lkvc_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [CAP_W-1:0] cfg_wr_data,  // capacity
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [63:0]      s_tdata,      // key [31:0], write_value [63:32]
	input  logic             s_tuser,      // opcode
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [63:0]      m_tdata,      // read_value [31:0], evicted_key [63:32]
	output logic [1:0]       m_tuser       // hit [0], evicted [1]
);

	localparam int FW   = $clog2(ENTRIES + 1);
	localparam int CMPW = ((FW > CAP_W) ? FW : CAP_W) + 1;

	state_t state_q, state_d;

	logic [CAP_W-1:0]  cap_q;
	logic [FW-1:0]     fill_q;
	logic              op_q;
	logic [KEY_W-1:0]  key_q;
	logic [DATA_W-1:0] wval_q;
	logic              m_tvalid_q;
	logic [63:0]       m_tdata_q;
	logic [1:0]        m_tuser_q;

	logic accept, out_free, upd_fire;
	logic any_hit, full, ins_free, ins_evict;
	logic [CMPW-1:0] eff_cap;
	logic [DATA_W-1:0] hit_data;
	logic [KEY_W-1:0]  tail_key;
	entry_t head;

	entry_t             ent [ENTRIES];
	logic [ENTRIES-1:0] match, tail, take, hit_zone;

	assign accept   = s_tvalid & s_tready;
	assign out_free = ~m_tvalid_q | m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_UPDATE;
			ST_UPDATE: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		upd_fire = 1'b0;
		unique case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_UPDATE: upd_fire = out_free;
			default:   s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cap_q   <= CAP_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= s_tuser;
			key_q  <= s_tdata[KEY_W-1:0];
			wval_q <= s_tdata[KEY_W +: DATA_W];
		end
	end

	// Capacity zero behaves as one; anything above the slot count saturates.
	always_comb begin
		eff_cap = CMPW'(cap_q);
		if (cap_q == '0) begin
			eff_cap = CMPW'(1);
		end else if (eff_cap > CMPW'(ENTRIES)) begin
			eff_cap = CMPW'(ENTRIES);
		end
	end

	assign any_hit   = |match;
	assign full      = CMPW'(fill_q) >= eff_cap;
	assign ins_free  = (op_q == OP_PUT) & ~any_hit & ~full;
	assign ins_evict = (op_q == OP_PUT) & ~any_hit & full;

	always_comb begin
		hit_data = '0;
		tail_key = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_data = hit_data | ({DATA_W{match[i]}} & ent[i].data);
			tail_key = tail_key | ({KEY_W{tail[i]}} & ent[i].key);
		end
	end

	assign head = '{valid: 1'b1, key: key_q,
		data: (op_q == OP_PUT) ? wval_q : hit_data};

	// On a hit, the head and every cell down to the matching one move by one slot.
	always_comb begin
		logic run;
		run = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_zone[i] = ~run;
			run         = run | match[i];
			take[i]     = upd_fire & (ins_free | (ins_evict & ent[i].valid)
				| (any_hit & hit_zone[i]));
		end
	end

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		entry_t prev_ent;
		logic   nxt_valid;

		if (g == 0) begin : g_head
			assign prev_ent = head;
		end else begin : g_body
			assign prev_ent = ent[g-1];
		end

		if (g == ENTRIES - 1) begin : g_last
			assign nxt_valid = 1'b0;
		end else begin : g_mid
			assign nxt_valid = ent[g+1].valid;
		end

		lkvc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmp_en     (accept),
			.cmp_key    (s_tdata[KEY_W-1:0]),
			.take       (take[g]),
			.prev       (prev_ent),
			.next_valid (nxt_valid),
			.ent        (ent[g]),
			.match      (match[g]),
			.tail       (tail[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (upd_fire && ins_free) begin
				fill_q <= fill_q + FW'(1);
			end
			if (upd_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			m_tuser_q <= {ins_evict, any_hit};
			m_tdata_q <= {(ins_evict ? tail_key : {KEY_W{1'b0}}),
				((op_q == OP_GET && any_hit) ? hit_data : {DATA_W{1'b0}})};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// File: rtl/lkvc_checker.sv
// Port-level checks for the LRU key/value cache, bound to the top level.
// Depends on lkvc_pkg and lru_key_value_cache.
module lkvc_checker import lkvc_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             cfg_wr_en,
	input logic [CAP_W-1:0] cfg_wr_data,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic [63:0]      s_tdata,
	input logic             s_tuser,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [63:0]      m_tdata,
	input logic [1:0]       m_tuser
);

	// The block works on one transaction at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item was in progress");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without an update cycle");

	a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tuser[0])
		else $error("eviction reported together with a hit");

	a_evicted_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[1] |-> m_tdata[63:32] == 32'd0)
		else $error("evicted key nonzero without an eviction");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);

// File: verif/testbench.sv
// Self-checking testbench for lru_key_value_cache: directed get/put table, then random phases.
// Predicts each transaction with an in-bench LRU model; depends on lkvc_pkg and the RTL only.
module testbench;
	import lkvc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES      = ENTRIES_DEF;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_ITEMS  = 100;
	localparam int POOL_SIZE    = 12;
	localparam int IDLE_PERCENT = 7;

	typedef struct packed {
		logic              hit;
		logic [DATA_W-1:0] read_value;
		logic              evicted;
		logic [KEY_W-1:0]  evicted_key;
	} reply_t;

	typedef struct packed {
		logic              op;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] value;
		logic              typed;
		reply_t            reply;
	} access_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wr_en = 1'b0;
	logic [CAP_W-1:0] cfg_wr_data = '0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [63:0]      s_tdata = '0;   // key [31:0], write_value [63:32]
	logic             s_tuser = 1'b0; // opcode
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [63:0]      m_tdata;        // read_value [31:0], evicted_key [63:32]
	logic [1:0]       m_tuser;        // hit [0], evicted [1]

	// Shadow copy of the cache contents and the capacity register.
	logic              slot_valid [ENTRIES] = '{default: 1'b0};
	logic [KEY_W-1:0]  slot_key   [ENTRIES] = '{default: '0};
	logic [DATA_W-1:0] slot_data  [ENTRIES] = '{default: '0};
	int unsigned       slot_rank  [ENTRIES] = '{default: 0};
	int unsigned       fill_count = 0;
	logic [CAP_W-1:0]  capacity_setting = CAP_RESET;

	reply_t           pending_replies [$];
	access_row_t      directed_rows [$];
	logic [KEY_W-1:0] key_pool [POOL_SIZE];
	int               error_count = 0;
	int               requests_sent = 0;
	int               replies_seen = 0;
	int               cycle_count = 0;

	lru_key_value_cache #(
		.ENTRIES(ENTRIES)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

	always #5 clk = ~clk;

	// Entry s becomes the most recent; valid entries that were more recent age by one.
	function automatic void make_most_recent(input int s);
		int i;
		for (i = 0; i < ENTRIES; i++) begin
			if (slot_valid[i] && i != s && slot_rank[i] < slot_rank[s])
				slot_rank[i]++;
		end
		slot_rank[s] = 0;
	endfunction

	function automatic reply_t predict_access(input logic op, input logic [KEY_W-1:0] k,
			input logic [DATA_W-1:0] v);
		reply_t      r;
		int          i;
		int          hit_slot;
		int          victim;
		int          free_slot;
		int unsigned oldest;
		int unsigned limit;
		r = '0;
		hit_slot = -1;
		victim = -1;
		free_slot = -1;
		oldest = 0;
		limit = (capacity_setting == '0) ? 32'd1 : 32'(capacity_setting);
		if (limit > ENTRIES)
			limit = ENTRIES;
		for (i = 0; i < ENTRIES; i++) begin
			if (hit_slot < 0 && slot_valid[i] && slot_key[i] == k)
				hit_slot = i;
		end
		if (hit_slot >= 0) begin
			r.hit = 1'b1;
			if (op == OP_GET)
				r.read_value = slot_data[hit_slot];
			else
				slot_data[hit_slot] = v;
			make_most_recent(hit_slot);
		end else if (op == OP_PUT) begin
			if (fill_count >= limit) begin
				for (i = 0; i < ENTRIES; i++) begin
					if (slot_valid[i] && (victim < 0 || slot_rank[i] > oldest)) begin
						victim = i;
						oldest = slot_rank[i];
					end
				end
			end
			if (victim >= 0) begin
				r.evicted = 1'b1;
				r.evicted_key = slot_key[victim];
				slot_key[victim] = k;
				slot_data[victim] = v;
				make_most_recent(victim);
			end else begin
				for (i = ENTRIES - 1; i >= 0; i--) begin
					if (!slot_valid[i])
						free_slot = i;
				end
				if (free_slot >= 0) begin
					for (i = 0; i < ENTRIES; i++) begin
						if (slot_valid[i])
							slot_rank[i]++;
					end
					slot_valid[free_slot] = 1'b1;
					slot_key[free_slot] = k;
					slot_data[free_slot] = v;
					slot_rank[free_slot] = 0;
					fill_count++;
				end
			end
		end
		return r;
	endfunction

	function automatic access_row_t make_row(input logic op, input logic [KEY_W-1:0] k,
			input logic [DATA_W-1:0] v, input logic typed, input logic hit,
			input logic [DATA_W-1:0] rd, input logic ev, input logic [KEY_W-1:0] evk);
		access_row_t row;
		row.op = op;
		row.key = k;
		row.value = v;
		row.typed = typed;
		row.reply.hit = hit;
		row.reply.read_value = rd;
		row.reply.evicted = ev;
		row.reply.evicted_key = evk;
		return row;
	endfunction

	function automatic bit sender_idles();
		if (requests_sent >= 450 && requests_sent < 620)
			return 1'b0;
		return $urandom_range(99) < IDLE_PERCENT;
	endfunction

	// Called and returns at a falling edge. The prediction is queued once the
	// transaction is accepted; a typed row overrides the predicted reply.
	task automatic send_access(input logic op, input logic [KEY_W-1:0] k,
			input logic [DATA_W-1:0] v, input logic typed, input reply_t typed_reply);
		reply_t predicted;
		while (sender_idles()) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {v, k};
		s_tuser <= op;
		do
			@(posedge clk);
		while (!s_tready);
		predicted = predict_access(op, k, v);
		pending_replies.push_back(typed ? typed_reply : predicted);
		requests_sent++;
		@(negedge clk);
	endtask

	// Only written with the cache drained; the extra cycles cover the reorder stage.
	task automatic write_capacity(input logic [CAP_W-1:0] c);
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= c;
		capacity_setting = c;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_access();
		logic              op;
		logic [KEY_W-1:0]  k;
		logic [DATA_W-1:0] v;
		op = 1'($urandom_range(1));
		k = ($urandom_range(99) < 75) ? key_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
		v = $urandom;
		send_access(op, k, v, 1'b0, '0);
		// A put is often read straight back.
		if (op == OP_PUT && $urandom_range(99) < 30)
			send_access(OP_GET, k, $urandom, 1'b0, '0);
	endtask

	// Receiver: random backpressure, one long hold-off, and a quiet stretch.
	int  hold_left = 0;
	bit  long_hold_done = 1'b0;
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!long_hold_done && replies_seen >= 250) begin
			long_hold_done = 1'b1;
			hold_left = 60;
			m_tready <= 1'b0;
		end else if (replies_seen >= 480 && replies_seen < 650) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	always @(posedge clk) begin
		reply_t expected;
		if (arst_n && m_tvalid && m_tready) begin
			replies_seen++;
			if (pending_replies.size() == 0) begin
				$error("unexpected result transaction: %h / %b", m_tdata, m_tuser);
				error_count++;
			end else begin
				expected = pending_replies.pop_front();
				if (m_tuser[0] !== expected.hit) begin
					$error("hit: expected %0d, got %0d", expected.hit, m_tuser[0]);
					error_count++;
				end
				if (m_tdata[31:0] !== expected.read_value) begin
					$error("read_value: expected %h, got %h", expected.read_value,
						m_tdata[31:0]);
					error_count++;
				end
				if (m_tuser[1] !== expected.evicted) begin
					$error("evicted: expected %0d, got %0d", expected.evicted, m_tuser[1]);
					error_count++;
				end
				if (m_tdata[63:32] !== expected.evicted_key) begin
					$error("evicted_key: expected %h, got %h", expected.evicted_key,
						m_tdata[63:32]);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		logic [CAP_W-1:0] phase_caps [10];
		int               p;
		int               i;
		int               phase_start;

		// Capacity 8 after reset: extremes of key and value, hits, updates, first evictions.
		directed_rows.push_back(make_row(OP_GET, 32'h0000_0000, 32'hffff_ffff, 1'b1,
			1'b0, 32'h0, 1'b0, 32'h0));
		directed_rows.push_back(make_row(OP_PUT, 32'h8000_0000, 32'h7fff_ffff, 1'b1,
			1'b0, 32'h0, 1'b0, 32'h0));
		directed_rows.push_back(make_row(OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1,
			1'b1, 32'h7fff_ffff, 1'b0, 32'h0));
		directed_rows.push_back(make_row(OP_PUT, 32'h7fff_ffff, 32'h8000_0000, 1'b1,
			1'b0, 32'h0, 1'b0, 32'h0));
		directed_rows.push_back(make_row(OP_PUT, 32'hffff_ffff, 32'hffff_ffff, 1'b1,
			1'b0, 32'h0, 1'b0, 32'h0));
		directed_rows.push_back(make_row(OP_PUT, 32'h0000_0000, 32'h0000_0000, 1'b1,
			1'b0, 32'h0, 1'b0, 32'h0));
		directed_rows.push_back(make_row(OP_GET, 32'hffff_ffff, 32'h1234_5678, 1'b1,
			1'b1, 32'hffff_ffff, 1'b0, 32'h0));
		directed_rows.push_back(make_row(OP_PUT, 32'h8000_0000, 32'h0000_0001, 1'b1,
			1'b1, 32'h0, 1'b0, 32'h0));
		directed_rows.push_back(make_row(OP_GET, 32'h0000_0001, 32'hffff_ffff, 1'b1,
			1'b0, 32'h0, 1'b0, 32'h0));
		for (i = 1; i <= 4; i++)
			directed_rows.push_back(make_row(OP_PUT, i, 32'h100 + i, 1'b0,
				1'b0, 32'h0, 1'b0, 32'h0));
		directed_rows.push_back(make_row(OP_PUT, 32'h5, 32'hdead_beef, 1'b0,
			1'b0, 32'h0, 1'b0, 32'h0));
		directed_rows.push_back(make_row(OP_GET, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0, 32'h0));
		directed_rows.push_back(make_row(OP_PUT, 32'h6, 32'h5555_aaaa, 1'b0,
			1'b0, 32'h0, 1'b0, 32'h0));
		directed_rows.push_back(make_row(OP_GET, 32'h7fff_ffff, 32'h0, 1'b0,
			1'b0, 32'h0, 1'b0, 32'h0));
		directed_rows.push_back(make_row(OP_GET, 32'h8000_0000, 32'h0, 1'b0,
			1'b0, 32'h0, 1'b0, 32'h0));
		directed_rows.push_back(make_row(OP_PUT, 32'h0000_0001, 32'haaaa_5555, 1'b0,
			1'b0, 32'h0, 1'b0, 32'h0));

		// Dropping to 1 with a full cache, then zero, oversized, and ordinary sizes.
		phase_caps = '{4'd1, 4'd0, 4'd15, 4'd8, 4'd3, 4'd10, 4'd2, 4'd8, 4'd5, 4'd1};
		for (p = 7; p < 10; p++)
			phase_caps[p] = CAP_W'($urandom_range(15));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_access(directed_rows[i].op, directed_rows[i].key, directed_rows[i].value,
				directed_rows[i].typed, directed_rows[i].reply);

		for (p = 0; p < 10; p++) begin
			write_capacity(phase_caps[p]);
			foreach (key_pool[i])
				key_pool[i] = $urandom;
			if (p % 3 == 0) begin
				key_pool[0] = 32'h8000_0000;
				key_pool[1] = 32'h7fff_ffff;
				key_pool[2] = 32'hffff_ffff;
			end
			phase_start = requests_sent;
			while (requests_sent - phase_start < PHASE_ITEMS - 10)
				random_access();
		end

		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// File: filelist.f
rtl/lkvc_pkg.sv
rtl/lkvc_cell.sv
rtl/lru_key_value_cache.sv
rtl/lkvc_checker.sv
verif/testbench.sv
